FILE: hw/rtl/msdm_pkg.sv
`default_nettype none

package msdm_pkg;

  localparam int unsigned DELAY_DEPTH_DEF = 4096;
  localparam int unsigned SAMPLE_BITS_DEF = 24;

  localparam int unsigned OFF_W      = 11;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned GAIN_FRAC  = 15;
  localparam int unsigned GAIN_UNITY = 32768;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // reciprocal shift for offset modulo depth
  localparam int unsigned RECIP_SHIFT = 22;

  // output queue
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_AW    = 3;
  localparam int unsigned FIFO_CW    = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY_OFFSET = 2'd0,
    CFG_MID_GAIN     = 2'd1,
    CFG_SIDE_GAIN    = 2'd2
  } cfg_reg_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mid_side_delay_matrix_unit.sv
// A request passes through stages 1 to 4 and then the output queue before out_valid rises.
// Throughput: one frame per cycle while in_stall is low; one delay-memory write and one read per frame,
// results buffered in an 8-entry output queue so input keeps flowing under output stall until 8 are in flight.
// Reset: control, pointers and config registers cleared (gains to unity); the delay
// memory is not swept, entries not yet written since reset read as zero via fill tracking.
`default_nettype none

module mid_side_delay_matrix_unit #(
  parameter int unsigned DELAY_DEPTH = msdm_pkg::DELAY_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS = msdm_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,

  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0]    in_mid_sample,
  input  wire logic signed [SAMPLE_BITS-1:0]    in_return_sample,

  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic signed [SAMPLE_BITS-1:0]         out_mid_out,
  output logic signed [SAMPLE_BITS-1:0]         out_side_out,
  output logic signed [SAMPLE_BITS-1:0]         out_left_out,
  output logic signed [SAMPLE_BITS-1:0]         out_right_out,

  input  wire logic                             cfg_we,
  input  wire logic [msdm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [msdm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  import msdm_pkg::*;

  localparam int unsigned SB   = SAMPLE_BITS;
  localparam int unsigned AW   = $clog2(DELAY_DEPTH);
  localparam int unsigned PW   = OFF_W + RECIP_SHIFT;
  localparam int unsigned RW   = OFF_W + AW + 1;
  localparam int unsigned MW   = SB + GAIN_W + 1;
  localparam int unsigned SW   = SB + 2;
  localparam int unsigned TW   = SB + 3;

  localparam logic [PW-1:0] RECIP_MUL = PW'((64'd1 << RECIP_SHIFT) / DELAY_DEPTH);
  localparam logic [RW-1:0] DEPTH_R   = RW'(DELAY_DEPTH);
  localparam logic [AW:0]   DEPTH_A   = (AW+1)'(DELAY_DEPTH);
  localparam logic [AW-1:0] WP_LAST   = AW'(DELAY_DEPTH - 1);

  localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};

  // config
  logic [OFF_W-1:0]  off_r;
  logic [OFF_W-1:0]  offq_r;
  logic [GAIN_W-1:0] mid_gain_r;
  logic [GAIN_W-1:0] side_gain_r;
  logic [AW-1:0]     offm_r;
  logic [PW-1:0]     off_prod;
  logic [RW-1:0]     off_qd;
  logic [RW-1:0]     off_rem0;
  logic [RW-1:0]     off_rem;

  // write side
  logic              in_acc;
  logic              out_acc;
  logic [AW-1:0]     wp_r;
  logic              wrapped_r;
  logic [FIFO_CW-1:0] occ_r;
  logic [FIFO_CW-1:0] occ_nxt;

  // stage 1: memory access
  logic                 s1_v_r;
  logic signed [SB-1:0] s1_mid_r;
  logic signed [SB-1:0] s1_ret_r;
  logic [AW-1:0]        s1_wp_r;
  logic                 s1_wrapped_r;
  logic [AW:0]          rp_ext;
  logic [AW-1:0]        rd_addr;

  logic [SB-1:0] mem [DELAY_DEPTH];

  // stage 2: side
  logic                 s2_v_r;
  logic signed [SB-1:0] s2_mid_r;
  logic signed [SB-1:0] s2_ret_r;
  logic [SB-1:0]        s2_rdata_r;
  logic                 s2_zero_r;
  logic                 s2_fill_r;
  logic signed [SB-1:0] delayed;
  logic signed [SB:0]   side_diff;
  logic signed [SB-1:0] side_nxt;

  // stage 3: multiply
  logic                 s3_v_r;
  logic signed [SB-1:0] s3_mid_r;
  logic signed [SB-1:0] s3_side_r;

  // stage 4: combine
  logic                 s4_v_r;
  logic signed [SB-1:0] s4_mid_r;
  logic signed [SB-1:0] s4_side_r;
  logic signed [MW-1:0] s4_pm_r;
  logic signed [MW-1:0] s4_ps_r;
  logic signed [SW-1:0] ms;
  logic signed [SW-1:0] ss;
  logic signed [TW-1:0] lsum;
  logic signed [TW-1:0] rdif;
  logic signed [SB-1:0] left_nxt;
  logic signed [SB-1:0] right_nxt;

  // output queue
  logic signed [SB-1:0] q_mid   [FIFO_DEPTH];
  logic signed [SB-1:0] q_side  [FIFO_DEPTH];
  logic signed [SB-1:0] q_left  [FIFO_DEPTH];
  logic signed [SB-1:0] q_right [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   q_wr_r;
  logic [FIFO_AW-1:0]   q_rd_r;
  logic [FIFO_CW-1:0]   q_cnt_r;
  logic [FIFO_CW-1:0]   q_cnt_nxt;

  // ---------------- configuration ----------------
  assign off_prod = {{RECIP_SHIFT{1'b0}}, cfg_wdata[OFF_W-1:0]} * RECIP_MUL;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r       <= '0;
      offq_r      <= '0;
      mid_gain_r  <= GAIN_W'(GAIN_UNITY);
      side_gain_r <= GAIN_W'(GAIN_UNITY);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DELAY_OFFSET: begin
          off_r  <= cfg_wdata[OFF_W-1:0];
          offq_r <= off_prod[PW-1:RECIP_SHIFT];
        end
        CFG_MID_GAIN:  mid_gain_r  <= cfg_wdata[GAIN_W-1:0];
        CFG_SIDE_GAIN: side_gain_r <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // offset modulo depth: quotient estimate is exact or one low
  always_comb begin
    off_qd   = RW'(offq_r) * DEPTH_R;
    off_rem0 = RW'(off_r) - off_qd;
    off_rem  = (off_rem0 >= DEPTH_R) ? off_rem0 - DEPTH_R : off_rem0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offm_r <= '0;
    end else begin
      offm_r <= off_rem[AW-1:0];
    end
  end

  // ---------------- flow control ----------------
  assign in_stall  = (occ_r == FIFO_CW'(FIFO_DEPTH));
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (q_cnt_r != '0);
  assign out_acc   = out_valid && !out_stall;

  always_comb begin
    occ_nxt = occ_r;
    if (in_acc && !out_acc) begin
      occ_nxt = occ_r + 1'b1;
    end else if (!in_acc && out_acc) begin
      occ_nxt = occ_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r     <= '0;
      wp_r      <= '0;
      wrapped_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
      if (in_acc) begin
        if (wp_r == WP_LAST) begin
          wp_r      <= '0;
          wrapped_r <= 1'b1;
        end else begin
          wp_r <= wp_r + 1'b1;
        end
      end
    end
  end

  // ---------------- stage 1 ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    s1_mid_r     <= in_mid_sample;
    s1_ret_r     <= in_return_sample;
    s1_wp_r      <= wp_r;
    s1_wrapped_r <= wrapped_r;
  end

  always_comb begin
    if (s1_wp_r >= offm_r) begin
      rp_ext = {1'b0, s1_wp_r} - {1'b0, offm_r};
    end else begin
      rp_ext = {1'b0, s1_wp_r} + DEPTH_A - {1'b0, offm_r};
    end
  end
  assign rd_addr = rp_ext[AW-1:0];

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      mem[s1_wp_r] <= s1_mid_r;
    end
    s2_rdata_r <= mem[rd_addr];
  end

  // ---------------- stage 2 ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_mid_r  <= s1_mid_r;
    s2_ret_r  <= s1_ret_r;
    s2_zero_r <= (offm_r == '0);
    s2_fill_r <= s1_wrapped_r || (rd_addr < s1_wp_r);
  end

  always_comb begin
    if (s2_zero_r) begin
      delayed = s2_mid_r;
    end else if (s2_fill_r) begin
      delayed = $signed(s2_rdata_r);
    end else begin
      delayed = '0;
    end
    side_diff = $signed({delayed[SB-1], delayed}) - $signed({s2_ret_r[SB-1], s2_ret_r});
    if (side_diff[SB] != side_diff[SB-1]) begin
      side_nxt = side_diff[SB] ? SMIN : SMAX;
    end else begin
      side_nxt = side_diff[SB-1:0];
    end
  end

  // ---------------- stage 3 ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_mid_r  <= s2_mid_r;
    s3_side_r <= side_nxt;
  end

  // ---------------- stage 4 ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_mid_r  <= s3_mid_r;
    s4_side_r <= s3_side_r;
    s4_pm_r   <= s3_mid_r * $signed({1'b0, mid_gain_r});
    s4_ps_r   <= s3_side_r * $signed({1'b0, side_gain_r});
  end

  // arithmetic shift gives floor division by 2^15
  always_comb begin
    ms   = $signed(s4_pm_r[MW-1:GAIN_FRAC]);
    ss   = $signed(s4_ps_r[MW-1:GAIN_FRAC]);
    lsum = $signed({ms[SW-1], ms}) + $signed({ss[SW-1], ss});
    rdif = $signed({ms[SW-1], ms}) - $signed({ss[SW-1], ss});
    if ((&lsum[TW-1:SB-1]) || !(|lsum[TW-1:SB-1])) begin
      left_nxt = lsum[SB-1:0];
    end else begin
      left_nxt = lsum[TW-1] ? SMIN : SMAX;
    end
    if ((&rdif[TW-1:SB-1]) || !(|rdif[TW-1:SB-1])) begin
      right_nxt = rdif[SB-1:0];
    end else begin
      right_nxt = rdif[TW-1] ? SMIN : SMAX;
    end
  end

  // ---------------- output queue ----------------
  always_comb begin
    q_cnt_nxt = q_cnt_r;
    if (s4_v_r && !out_acc) begin
      q_cnt_nxt = q_cnt_r + 1'b1;
    end else if (!s4_v_r && out_acc) begin
      q_cnt_nxt = q_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r  <= '0;
      q_rd_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
      if (s4_v_r) begin
        q_wr_r <= q_wr_r + 1'b1;
      end
      if (out_acc) begin
        q_rd_r <= q_rd_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s4_v_r) begin
      q_mid[q_wr_r]   <= s4_mid_r;
      q_side[q_wr_r]  <= s4_side_r;
      q_left[q_wr_r]  <= left_nxt;
      q_right[q_wr_r] <= right_nxt;
    end
  end

  assign out_mid_out   = q_mid[q_rd_r];
  assign out_side_out  = q_side[q_rd_r];
  assign out_left_out  = q_left[q_rd_r];
  assign out_right_out = q_right[q_rd_r];

  // ---------------- assertions ----------------
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= FIFO_CW'(FIFO_DEPTH))
    else $error("request occupancy above queue depth");

  a_occ_track: assert property (@(posedge clk) disable iff (!rst_n)
    (FIFO_CW'($countones({s1_v_r, s2_v_r, s3_v_r, s4_v_r})) + q_cnt_r) == occ_r)
    else $error("in-flight count disagrees with occupancy");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    s4_v_r |-> (q_cnt_r < FIFO_CW'(FIFO_DEPTH)))
    else $error("output queue written while full");

  a_offm_range: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> (offm_r <= WP_LAST))
    else $error("delay offset modulo out of range");

endmodule

`default_nettype wire
